@@ sv/combined_lcg_shuffle_rng_unit_defines.svh @@
// Assertion macros for the combined LCG shuffle generator.
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock, off during reset.
`define CLSRNG_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clsrng check failed");
// Next-cycle implication, sampled on clock, off during reset.
`define CLSRNG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clsrng check failed");
`else
`define CLSRNG_ASSERT(label, ante, cons)
`define CLSRNG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/clsrng_pkg.sv @@
// Shared constants and command type for the combined LCG shuffle generator.
package clsrng_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int WARMUP_EXTRA    = 8;
   localparam int RECIP_SHIFT     = 47;

   localparam logic [30:0] TOP_OUT = 31'd2147483562;

   // Per-generator constants: lane 0 is the first generator, lane 1 the second.
   localparam logic [31:0] LANE_MOD [2] = '{32'd2147483563, 32'd2147483399};
   localparam logic [15:0] LANE_MUL [2] = '{16'd40014, 16'd40692};
   localparam logic [15:0] LANE_QUO [2] = '{16'd53668, 16'd52774};
   localparam logic [13:0] LANE_REM [2] = '{14'd12211, 14'd3791};
   localparam logic [30:0] LANE_RST [2] = '{31'd1, 31'd123456789};
   localparam logic [31:0] LANE_RECIP [2] = '{
      32'((64'd1 << RECIP_SHIFT) / 64'd53668),
      32'((64'd1 << RECIP_SHIFT) / 64'd52774)
   };

   typedef struct packed {
      logic       seed_load;
      logic [1:0] gen_step;
      logic       warm_wr;
      logic       warm_last;
      logic       combine;
   } dp_cmd_type;

endpackage

@@ sv/clsrng_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module clsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/clsrng_ctrl.sv @@
// Sequencer for seeding, warm-up, generator steps and the shuffle combine.
module clsrng_ctrl import clsrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_cmd,
   output logic                           req_ready,
   input  logic                           out_free,
   output dp_cmd_type                     dp_cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] warm_addr
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
   localparam logic [2:0] STEP_LAST = 3'd4;

   typedef enum logic [1:0] {ST_IDLE, ST_WARM, ST_DRAW, ST_FIN} state_type;

   state_type      state_ff, state_in;
   logic [2:0]     ph_ff, ph_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           step_end;

   assign step_end  = (ph_ff == STEP_LAST);
   assign req_ready = (state_ff == ST_IDLE);
   assign warm_addr = cnt_ff[AW-1:0];

   always_comb begin
      dp_cmd             = '0;
      dp_cmd.seed_load   = (state_ff == ST_IDLE) && req_valid && req_cmd;
      dp_cmd.gen_step[0] = ((state_ff == ST_WARM) || (state_ff == ST_DRAW)) && step_end;
      dp_cmd.gen_step[1] = (state_ff == ST_DRAW) && step_end;
      dp_cmd.warm_wr     = (state_ff == ST_WARM) && step_end
                           && (cnt_ff < CW'(TABLE_DEPTH));
      dp_cmd.warm_last   = (state_ff == ST_WARM) && step_end && (cnt_ff == '0);
      dp_cmd.combine     = (state_ff == ST_FIN) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            ph_in = '0;
            if (req_valid) begin
               if (req_cmd) begin
                  cnt_in   = CW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
                  state_in = ST_WARM;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_WARM: begin
            if (step_end) begin
               ph_in = '0;
               if (cnt_ff == '0) begin
                  state_in = ST_DRAW;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         ST_DRAW: begin
            if (step_end) begin
               ph_in    = '0;
               state_in = ST_FIN;
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         ST_FIN: begin
            // hold until the output register can take the word
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ sv/clsrng_dp.sv @@
// Datapath: two Schrage generator lanes, shuffle table, index unit, output register.
module clsrng_dp import clsrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     dp_cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0] warm_addr,
   input  logic [30:0]                    seed,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [30:0]                    rsp_value,
   output logic                           out_free
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IEW = $clog2(TABLE_DEPTH) + 2;
   localparam int NBW = IEW + 1 + 31;
   localparam longint BIN_L = 64'd1 + 64'd2147483562 / TABLE_DEPTH;
   localparam logic [30:0] BIN = 31'(BIN_L);
   localparam logic [31:0] RECIPB = 32'((64'd1 << RECIP_SHIFT) / BIN_L);

   logic [30:0] x_ff [2];
   logic [30:0] v    [2];
   logic [30:0] seed_v;

   assign seed_v = (seed == '0) ? 31'd1 : seed;

   // Schrage step per lane: k by reciprocal, one correction, then mul*r - k*rem.
   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [62:0] prod;
      logic [15:0] k_ff;
      logic [31:0] kq_ff;
      logic [31:0] diff;
      logic [15:0] kc_in, rc_in, kc_ff, rc_ff;
      logic [31:0] a_ff, b_ff;
      logic [32:0] d;

      assign prod = 63'(x_ff[g]) * 63'(LANE_RECIP[g]);

      always_comb begin
         diff = {1'b0, x_ff[g]} - kq_ff;
         if (diff >= 32'(LANE_QUO[g])) begin
            kc_in = k_ff + 1'b1;
            rc_in = 16'(diff - 32'(LANE_QUO[g]));
         end else begin
            kc_in = k_ff;
            rc_in = diff[15:0];
         end
         d = {1'b0, a_ff} - {1'b0, b_ff};
         if (d[32]) begin
            v[g] = 31'(d + 33'(LANE_MOD[g]));
         end else begin
            v[g] = d[30:0];
         end
      end

      always_ff @(posedge clock) begin
         k_ff  <= prod[RECIP_SHIFT +: 16];
         kq_ff <= 32'(k_ff) * 32'(LANE_QUO[g]);
         kc_ff <= kc_in;
         rc_ff <= rc_in;
         a_ff  <= 32'(rc_ff) * 32'(LANE_MUL[g]);
         b_ff  <= 32'(kc_ff) * 32'(LANE_REM[g]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            x_ff[g] <= LANE_RST[g];
         end else if (dp_cmd.seed_load) begin
            x_ff[g] <= seed_v;
         end else if (dp_cmd.gen_step[g]) begin
            x_ff[g] <= v[g];
         end
      end
   end

   // Table index from the previous output: reciprocal estimate, one correction, then a clamp to the last entry.
   logic [30:0]    last_ff, last_in;
   logic [62:0]    iprod;
   logic [IEW-1:0] iest_ff;
   logic [IEW:0]   inc;
   logic [NBW-1:0] nb;
   logic [IEW:0]   cand;
   logic [AW-1:0]  idx_ff, idx_in;

   assign iprod = 63'(last_ff) * 63'(RECIPB);
   assign inc   = {1'b0, iest_ff} + 1'b1;
   assign nb    = NBW'(inc) * NBW'(BIN);

   always_comb begin
      if (nb <= NBW'(last_ff)) begin
         cand = inc;
      end else begin
         cand = {1'b0, iest_ff};
      end
      if (cand > (IEW + 1)'(TABLE_DEPTH - 1)) begin
         idx_in = AW'(TABLE_DEPTH - 1);
      end else begin
         idx_in = cand[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      iest_ff <= iprod[RECIP_SHIFT +: IEW];
      idx_ff  <= idx_in;
   end

   // Shuffle table; entries never written read as zero.
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [30:0]            wr_data;
   logic [30:0]            rd_data;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                   rvalid_ff;
   logic [30:0]            entry;

   assign wr_en   = dp_cmd.warm_wr || dp_cmd.combine;
   assign wr_addr = dp_cmd.combine ? idx_ff : warm_addr;
   assign wr_data = dp_cmd.combine ? x_ff[0] : v[0];

   clsrng_ram #(
      .WIDTH (31),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rvalid_ff <= valid_ff[idx_ff];
   end

   assign entry = rvalid_ff ? rd_data : '0;

   // Combine the picked entry with the second generator.
   logic [31:0] dc;
   logic [30:0] mix;

   always_comb begin
      dc = {1'b0, entry} - {1'b0, x_ff[1]};
      if (dc[31] || (dc == '0)) begin
         mix = 31'(dc + {1'b0, TOP_OUT});
      end else begin
         mix = dc[30:0];
      end
      last_in = last_ff;
      if (dp_cmd.combine) begin
         last_in = mix;
      end else if (dp_cmd.warm_last) begin
         last_in = v[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   // Output register.
   logic        rsp_valid_ff;
   logic [30:0] rsp_value_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.combine) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.combine) begin
         rsp_value_ff <= mix;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

@@ sv/combined_lcg_shuffle_rng_unit.sv @@
// Draw: both generators step, then the combine fills the output register; no new request
// is taken before the combine. Seed: TABLE_DEPTH+8 warm-up steps (forty at depth 32).
// Each generator step runs the 5-stage Schrage unit (reciprocal, multiply, correct,
// multiply, reduce); both generators step together in the draw.
// Reset (synchronous, active high): generators 1 and 123456789, last output 0,
// table valid bits cleared so the table reads as zeros; no clearing pass.
`include "combined_lcg_shuffle_rng_unit_defines.svh"
module combined_lcg_shuffle_rng_unit import clsrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] seed, [31] zero
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [30:0] value, [31] zero
);

   dp_cmd_type                     dp_cmd;
   logic [$clog2(TABLE_DEPTH)-1:0] warm_addr;
   logic                           out_free;
   logic [30:0]                    rsp_value;

   clsrng_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser[0]),
      .req_ready (req_tready),
      .out_free  (out_free),
      .dp_cmd    (dp_cmd),
      .warm_addr (warm_addr)
   );

   clsrng_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .warm_addr (warm_addr),
      .seed      (req_tdata[30:0]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_value (rsp_value),
      .out_free  (out_free)
   );

   assign rsp_tdata = {1'b0, rsp_value};

   `CLSRNG_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `CLSRNG_ASSERT(a_combine_needs_slot, dp_cmd.combine, !rsp_tvalid || rsp_tready)
   `CLSRNG_ASSERT(a_no_step_on_seed, dp_cmd.seed_load, dp_cmd.gen_step == 2'b00)
   `CLSRNG_ASSERT_NEXT(a_combine_shows_word, dp_cmd.combine, rsp_tvalid)

endmodule
